@@ sv/cssd_pkg.sv @@
// Shared types and constants for the checksummed sentence decoder.
// No dependencies; every other file imports this package.
package cssd_pkg;

    // Characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // Keywords, packed first character in the top byte
    localparam logic [23:0] KW_CHA = 24'h434841;
    localparam logic [23:0] KW_ACC = 24'h414343;
    localparam logic [23:0] KW_REV = 24'h524556;
    localparam logic [23:0] KW_SHO = 24'h53484F;
    localparam logic [23:0] KW_RES = 24'h524553;

    localparam logic [2:0] KIND_CHA = 3'd0;
    localparam logic [2:0] KIND_ACC = 3'd1;
    localparam logic [2:0] KIND_REV = 3'd2;
    localparam logic [2:0] KIND_SHO = 3'd3;
    localparam logic [2:0] KIND_RES = 3'd4;

    localparam int DEFAULT_FIELD_BITS = 16;
    localparam int OUT_FIELD_W        = 16;

    // Register map
    localparam int         APB_ADDR_W    = 2;
    localparam logic [1:0] ADDR_MAX_LEN  = 2'd0;
    localparam logic [7:0] MAX_LEN_RESET = 8'd64;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PAYLOAD,
        MODE_CHECK
    } frame_mode_t;

    typedef enum logic [1:0] {
        NUM_LEAD,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    typedef struct packed {
        logic                   status;
        logic                   event_valid;
        logic [2:0]             event_kind;
        logic [OUT_FIELD_W-1:0] field_a;
        logic [OUT_FIELD_W-1:0] field_b;
        logic [OUT_FIELD_W-1:0] field_c;
    } result_t;

endpackage

@@ sv/cssd_if.sv @@
// Valid/ready channel interfaces for the sentence decoder.
// Byte request channel and result channel; depend on cssd_pkg for widths.
interface cssd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface cssd_result_if;
    import cssd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   status;
    logic                   event_valid;
    logic [2:0]             event_kind;
    logic [OUT_FIELD_W-1:0] field_a;
    logic [OUT_FIELD_W-1:0] field_b;
    logic [OUT_FIELD_W-1:0] field_c;

    modport source (output valid, output status, output event_valid, output event_kind,
                    output field_a, output field_b, output field_c, input ready);
    modport sink   (input valid, input status, input event_valid, input event_kind,
                    input field_a, input field_b, input field_c, output ready);
endinterface

@@ sv/cssd_apb_regs.sv @@
// APB configuration register block: holds max_payload_len.
// Depends on cssd_pkg for the register map.
module cssd_apb_regs
    import cssd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [7:0]            max_len
);

    logic [7:0] max_len_reg;
    logic [7:0] max_len_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_MAX_LEN);

    always_comb
    begin
        max_len_next = max_len_reg;
        if (wr_en)
        begin
            max_len_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    assign prdata  = (paddr == ADDR_MAX_LEN) ? {24'd0, max_len_reg} : 32'd0;
    assign max_len = max_len_reg;

endmodule

@@ sv/cssd_core.sv @@
// Framer, tokeniser and field decoder state, plus the per-byte result logic.
// Depends on cssd_pkg; state advances only on an accepted byte.
module cssd_core
    import cssd_pkg::*;
#(
    parameter int FIELD_BITS = DEFAULT_FIELD_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] byte_in,
    input  logic [7:0] max_len,
    output result_t    res
);

    frame_mode_t            mode_reg, mode_next;
    logic [7:0]             count_reg, count_next;
    logic [7:0]             xor_reg, xor_next;
    logic [1:0]             hex_cnt_reg, hex_cnt_next;
    logic [7:0]             check_reg, check_next;
    logic [2:0]             tok_reg, tok_next;
    logic [23:0]            kw_reg, kw_next;
    logic [1:0]             kw_len_reg, kw_len_next;
    logic                   kw_long_reg, kw_long_next;
    logic                   in_tok_reg, in_tok_next;
    num_phase_t             phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [FIELD_BITS-1:0]  field_reg [3];
    logic [FIELD_BITS-1:0]  field_next [3];

    logic       is_digit;
    logic       is_blank;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       kw_known;
    logic [2:0] kind;
    logic [2:0] max_tok;
    logic       sentence_ok;
    logic       framing_err;

    assign is_digit = byte_in inside {[CH_0:CH_9]};
    assign is_blank = byte_in inside {CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'(byte_in - CH_0);
        if (is_digit)
        begin
            hex_val = 4'(byte_in - CH_0);
        end
        else if (byte_in inside {[CH_LA:CH_LF_HEX]})
        begin
            hex_val = 4'(byte_in - CH_LA + 8'd10);
        end
        else if (byte_in inside {[CH_UA:CH_UF]})
        begin
            hex_val = 4'(byte_in - CH_UA + 8'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        kw_known = 1'b1;
        kind     = KIND_CHA;
        max_tok  = 3'd2;
        case (kw_reg)
            KW_CHA: begin kind = KIND_CHA; max_tok = 3'd2; end
            KW_ACC: begin kind = KIND_ACC; max_tok = 3'd2; end
            KW_REV: begin kind = KIND_REV; max_tok = 3'd2; end
            KW_SHO: begin kind = KIND_SHO; max_tok = 3'd3; end
            KW_RES: begin kind = KIND_RES; max_tok = 3'd4; end
            default: kw_known = 1'b0;
        endcase
    end

    assign sentence_ok = (kw_len_reg == 2'd3) && !kw_long_reg && kw_known
                         && (tok_reg >= 3'd1) && (tok_reg <= max_tok)
                         && (check_reg == xor_reg);

    // count_reg saturates, so a limit of 255 never trips this
    assign framing_err = (byte_in == CH_DOLLAR) || (byte_in == CH_LF)
                         || (count_reg > max_len);

    // Next state
    always_comb
    begin
        logic                  do_clear;
        logic                  start;
        logic                  acc_en;
        logic [2:0]            tok_eff;
        num_phase_t            phase_eff;
        logic                  neg_eff;
        logic [1:0]            fsel;
        logic [FIELD_BITS-1:0] fval;
        logic [FIELD_BITS-1:0] times10;
        logic [FIELD_BITS-1:0] digit;

        mode_next     = mode_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        hex_cnt_next  = hex_cnt_reg;
        check_next    = check_reg;
        tok_next      = tok_reg;
        kw_next       = kw_reg;
        kw_len_next   = kw_len_reg;
        kw_long_next  = kw_long_reg;
        in_tok_next   = in_tok_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        field_next    = field_reg;
        do_clear      = 1'b0;
        start         = 1'b0;
        acc_en        = 1'b0;
        tok_eff       = tok_reg;
        phase_eff     = phase_reg;
        neg_eff       = neg_reg;
        fsel          = 2'(tok_reg - 3'd2);
        fval          = field_reg[0];
        times10       = '0;
        digit         = FIELD_BITS'(byte_in[3:0]);

        case (mode_reg)
            MODE_IDLE:
            begin
                if (byte_in == CH_DOLLAR)
                begin
                    do_clear = 1'b1;
                    start    = 1'b1;
                end
            end
            MODE_PAYLOAD:
            begin
                if (framing_err)
                begin
                    do_clear = 1'b1;
                end
                else if (byte_in == CH_STAR)
                begin
                    mode_next = MODE_CHECK;
                end
                else
                begin
                    xor_next = xor_reg ^ byte_in;
                    if (count_reg != 8'hFF)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                    if (byte_in == CH_COMMA)
                    begin
                        in_tok_next = 1'b0;
                    end
                    else
                    begin
                        if (!in_tok_reg)
                        begin
                            in_tok_next = 1'b1;
                            if (tok_reg != 3'd7)
                            begin
                                tok_eff = tok_reg + 3'd1;
                            end
                            phase_eff = NUM_LEAD;
                            neg_eff   = 1'b0;
                        end
                        tok_next   = tok_eff;
                        phase_next = phase_eff;
                        neg_next   = neg_eff;
                        if (tok_eff == 3'd1)
                        begin
                            if (kw_len_reg == 2'd3)
                            begin
                                kw_long_next = 1'b1;
                            end
                            else
                            begin
                                kw_next     = {kw_reg[15:0], byte_in};
                                kw_len_next = kw_len_reg + 2'd1;
                            end
                        end
                        else if (tok_eff >= 3'd2 && tok_eff <= 3'd4)
                        begin
                            fsel = 2'(tok_eff - 3'd2);
                            fval = field_reg[fsel];
                            if (phase_eff == NUM_LEAD)
                            begin
                                if (!is_blank)
                                begin
                                    if (byte_in == CH_PLUS || byte_in == CH_MINUS)
                                    begin
                                        neg_next   = (byte_in == CH_MINUS);
                                        phase_next = NUM_DIGITS;
                                    end
                                    else if (!is_digit)
                                    begin
                                        phase_next = NUM_DONE;
                                    end
                                    else
                                    begin
                                        phase_next = NUM_DIGITS;
                                        acc_en     = 1'b1;
                                    end
                                end
                            end
                            else if (phase_eff != NUM_DIGITS || !is_digit)
                            begin
                                phase_next = NUM_DONE;
                            end
                            else
                            begin
                                acc_en = 1'b1;
                            end
                            times10 = (fval << 3) + (fval << 1);
                            if (acc_en)
                            begin
                                field_next[fsel] = neg_eff ? (times10 - digit)
                                                           : (times10 + digit);
                            end
                        end
                    end
                end
            end
            MODE_CHECK:
            begin
                // a third digit is taken; the newline after it then fails
                if (hex_ok && hex_cnt_reg <= 2'd2)
                begin
                    check_next   = {check_reg[3:0], hex_val};
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end
                else
                begin
                    do_clear = 1'b1;
                end
            end
            default:
            begin
                do_clear = 1'b1;
            end
        endcase

        if (do_clear)
        begin
            mode_next    = start ? MODE_PAYLOAD : MODE_IDLE;
            count_next   = 8'd0;
            xor_next     = 8'd0;
            hex_cnt_next = 2'd0;
            check_next   = 8'd0;
            tok_next     = 3'd0;
            kw_next      = 24'd0;
            kw_len_next  = 2'd0;
            kw_long_next = 1'b0;
            in_tok_next  = 1'b0;
            phase_next   = NUM_LEAD;
            neg_next     = 1'b0;
            field_next   = '{default: '0};
        end
    end

    // Result for the byte presented now
    always_comb
    begin
        res = '0;
        case (mode_reg)
            MODE_IDLE:
            begin
                res.status = (byte_in != CH_DOLLAR);
            end
            MODE_PAYLOAD:
            begin
                res.status = framing_err;
            end
            MODE_CHECK:
            begin
                if (hex_ok && hex_cnt_reg <= 2'd2)
                begin
                    res.status = 1'b0;
                end
                else if (byte_in == CH_LF && hex_cnt_reg == 2'd2 && sentence_ok)
                begin
                    res.event_valid = 1'b1;
                    res.event_kind  = kind;
                    res.field_a     = OUT_FIELD_W'(field_reg[0]);
                    res.field_b     = OUT_FIELD_W'(field_reg[1]);
                    res.field_c     = OUT_FIELD_W'(field_reg[2]);
                end
                else
                begin
                    res.status = 1'b1;
                end
            end
            default:
            begin
                res.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            count_reg   <= 8'd0;
            xor_reg     <= 8'd0;
            hex_cnt_reg <= 2'd0;
            check_reg   <= 8'd0;
            tok_reg     <= 3'd0;
            kw_reg      <= 24'd0;
            kw_len_reg  <= 2'd0;
            kw_long_reg <= 1'b0;
            in_tok_reg  <= 1'b0;
            phase_reg   <= NUM_LEAD;
            neg_reg     <= 1'b0;
            field_reg   <= '{default: '0};
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            hex_cnt_reg <= hex_cnt_next;
            check_reg   <= check_next;
            tok_reg     <= tok_next;
            kw_reg      <= kw_next;
            kw_len_reg  <= kw_len_next;
            kw_long_reg <= kw_long_next;
            in_tok_reg  <= in_tok_next;
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            field_reg   <= field_next;
        end
    end

endmodule

@@ sv/cssd_result_reg.sv @@
// Output register for the result channel; decouples the two handshakes.
// Depends on cssd_pkg for result_t.
module cssd_result_reg
    import cssd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    can_load,
    output result_t res_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Room when empty or when the held result leaves this cycle
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

@@ sv/checksummed_sentence_decoder.sv @@
// Top level of the checksummed sentence decoder.
// Depends on cssd_pkg, cssd_if, cssd_apb_regs, cssd_core and cssd_result_reg.
//
// Usage:
//   rx  : byte request channel (valid/ready), one received character per request.
//   ev  : result channel, one result per accepted byte: status (1 = error, framer
//         back to idle), and on a newline closing a good sentence event_valid with
//         event_kind and up to three numeric fields (absent fields read 0).
//   APB : register 0 at byte address 0 is max_payload_len (8 bits, reset 64).
//         Write only while no requests are outstanding.
// Timing: a byte is accepted and decoded against the framer state in the same cycle,
//   and its result appears in the output register on the next cycle; throughput is
//   one byte per cycle while ev.ready keeps the output register draining. The rate
//   is set by the state update of the framer and field accumulators.
// Stall: when ev.ready is low the held result stays put and rx.ready drops until
//   it is taken; rx.ready is high whenever the output register is empty or draining.
// Reset: rst_n clears the framer to waiting for '$', empties the output register
//   and restores max_payload_len to 64.
module checksummed_sentence_decoder
    import cssd_pkg::*;
#(
    parameter int FIELD_BITS = DEFAULT_FIELD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    cssd_byte_if.sink             rx,
    cssd_result_if.source         ev,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic    accept;
    logic    can_load;
    logic    [7:0] max_len;
    result_t res_core;
    result_t res_held;

    assign rx.ready = can_load;
    assign accept   = rx.valid && can_load;

    cssd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    cssd_core #(
        .FIELD_BITS (FIELD_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (rx.byte_in),
        .max_len (max_len),
        .res     (res_core)
    );

    cssd_result_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (res_core),
        .out_ready (ev.ready),
        .out_valid (ev.valid),
        .can_load  (can_load),
        .res_out   (res_held)
    );

    assign ev.status      = res_held.status;
    assign ev.event_valid = res_held.event_valid;
    assign ev.event_kind  = res_held.event_kind;
    assign ev.field_a     = res_held.field_a;
    assign ev.field_b     = res_held.field_b;
    assign ev.field_c     = res_held.field_c;

endmodule

@@ sv/cssd_checker.sv @@
// Port-level checks for the sentence decoder, attached to the top by bind.
// Depends on cssd_pkg for kind codes and field widths.
module cssd_checker
    import cssd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   rx_valid,
    input logic                   rx_ready,
    input logic                   ev_valid,
    input logic                   ev_ready,
    input logic                   ev_status,
    input logic                   ev_event_valid,
    input logic [2:0]             ev_event_kind,
    input logic [OUT_FIELD_W-1:0] ev_field_a,
    input logic [OUT_FIELD_W-1:0] ev_field_b,
    input logic [OUT_FIELD_W-1:0] ev_field_c
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid && $stable(ev_status)
            && $stable(ev_event_valid) && $stable(ev_field_a))
        else $error("result changed while stalled");

    // Empty output register never back-pressures the byte channel
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !ev_valid |-> rx_ready)
        else $error("byte channel stalled with empty output");

    // Every accepted byte yields a result on the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready |=> ev_valid)
        else $error("accepted byte gave no result");

    // An event is never an error and names a known keyword
    a_event: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_event_valid |-> !ev_status && (ev_event_kind <= KIND_RES))
        else $error("bad event");

    // Without an event every payload field reads zero
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_event_valid |-> (ev_event_kind == KIND_CHA) && (ev_field_a == '0)
            && (ev_field_b == '0) && (ev_field_c == '0))
        else $error("fields set without event");

endmodule

bind checksummed_sentence_decoder cssd_checker u_cssd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_valid       (rx.valid),
    .rx_ready       (rx.ready),
    .ev_valid       (ev.valid),
    .ev_ready       (ev.ready),
    .ev_status      (ev.status),
    .ev_event_valid (ev.event_valid),
    .ev_event_kind  (ev.event_kind),
    .ev_field_a     (ev.field_a),
    .ev_field_b     (ev.field_b),
    .ev_field_c     (ev.field_c)
);
